/* design/assert_macros.svh */
// assertion macros shared by the calendar date stepper rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* design/cds_pkg.sv */
// shared types, constants and calendar functions for the date stepper
// no dependencies
package cds_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int COUNT_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 12'd4095;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 12'd1900;
    localparam logic [MONTH_W-1:0] MONTHS    = 4'd12;
    localparam logic [MONTH_W-1:0] FEB       = 4'd2;
    localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;
    localparam logic [DAY_W-1:0]   ODD_MONTH_LEN = 5'd31;

    // modular inverse of 25 mod 2^12: y is a multiple of 25 exactly when
    // y * INV25 (mod 2^12) lands at or below 4095 / 25
    localparam logic [YEAR_W-1:0] INV25       = 12'd3113;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT = 12'd163;

    localparam logic [DAY_W-1:0]   RESET_LATEST_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] RESET_LATEST_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0]  RESET_LATEST_YEAR  = 12'd2000;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_ADD  = 2'd1,
        ACT_SUB  = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LATEST_DAY   = 2'd0,
        CFG_LATEST_MONTH = 2'd1,
        CFG_LATEST_YEAR  = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_idx_t;

    // year first so a packed compare orders dates
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        logic not_after;
        logic earlier;
        logic valid;
    } flags_t;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] full;
        logic                div25;
        full  = y * INV25;
        div25 = (full[YEAR_W-1:0] <= DIV25_LIMIT);
        // div by 4 but not 100, or div by 400 (= div by 16 and 25)
        return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = ODD_MONTH_LEN;
        endcase
        return len;
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0] y);
        logic [DAY_W-1:0] len;
        if (m == FEB && is_leap(y))
            len = FEB_LEAP_LEN;
        else
            len = month_len(m);
        return len;
    endfunction

endpackage

/* design/cds_step_unit.sv */
// one-day step unit: moves a date one day forward or back
// depends on cds_pkg
module cds_step_unit (
    input  logic          back,
    input  cds_pkg::date_t cur,
    output cds_pkg::date_t nxt,
    output logic          ok
);
    import cds_pkg::*;

    logic                wrap;
    logic [MONTH_W-1:0]  sel_month;
    logic [YEAR_W-1:0]   sel_year;
    logic [DAY_W-1:0]    len;

    always_comb
    begin
        wrap = (cur.month <= 4'd1);
        // backward steps need the length of the previous month
        if (back)
        begin
            sel_month = wrap ? MONTHS : cur.month - 4'd1;
            sel_year  = wrap ? cur.year - 12'd1 : cur.year;
        end
        else
        begin
            sel_month = cur.month;
            sel_year  = cur.year;
        end
        len = days_in(sel_month, sel_year);

        nxt = cur;
        ok  = 1'b1;
        if (!back)
        begin
            if (cur.day >= len)
            begin
                if (cur.month >= MONTHS)
                begin
                    if (cur.year >= YEAR_MAX)
                        ok = 1'b0;
                    else
                    begin
                        nxt.year  = cur.year + 12'd1;
                        nxt.month = 4'd1;
                        nxt.day   = 5'd1;
                    end
                end
                else
                begin
                    nxt.month = cur.month + 4'd1;
                    nxt.day   = 5'd1;
                end
            end
            else
                nxt.day = cur.day + 5'd1;
        end
        else
        begin
            if (cur.day <= 5'd1)
            begin
                if (wrap && cur.year == '0)
                    ok = 1'b0;
                else
                begin
                    nxt.year  = sel_year;
                    nxt.month = sel_month;
                    nxt.day   = len;
                end
            end
            else
                nxt.day = cur.day - 5'd1;
        end
    end

endmodule

/* design/cds_check.sv */
// date compare and validity check on the stored date
// depends on cds_pkg
module cds_check (
    input  cds_pkg::date_t  cur,
    input  cds_pkg::date_t  ref_date,
    input  cds_pkg::date_t  latest,
    output cds_pkg::flags_t flags
);
    import cds_pkg::*;

    logic [DAY_W-1:0] len;

    always_comb
    begin
        len             = days_in(cur.month, cur.year);
        flags.not_after = (cur <= ref_date);
        flags.earlier   = (cur < ref_date);
        flags.valid     = (cur.year >= YEAR_MIN)
                       && (cur.month >= 4'd1) && (cur.month <= MONTHS)
                       && (cur.day >= 5'd1) && (cur.day <= len)
                       && (cur <= latest);
    end

endmodule

/* design/calendar_date_stepper_unit.sv */
// Calendar date stepper: holds one day/month/year date and loads it or moves
// it forward or back by day_count days (Gregorian leap years, year held in
// 0..4095). One request is taken at a time. A load or unused action passes
// through the step state with a zero count; an add or subtract counts
// day_count down there, since the shared step unit advances the date one
// day per clock, stopping at the year range. The request side stalls from
// acceptance until the result is taken. Configuration writes are always
// ready and take effect at once; write them only while no request is open.
// depends on cds_pkg, cds_step_unit, cds_check and assert_macros.svh
`include "assert_macros.svh"

module calendar_date_stepper_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [1:0]                        action,
    input  logic [cds_pkg::DAY_W-1:0]         in_day,
    input  logic [cds_pkg::MONTH_W-1:0]       in_month,
    input  logic [cds_pkg::YEAR_W-1:0]        in_year,
    input  logic [cds_pkg::COUNT_W-1:0]       day_count,
    // result channel
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [cds_pkg::DAY_W-1:0]         out_day,
    output logic [cds_pkg::MONTH_W-1:0]       out_month,
    output logic [cds_pkg::YEAR_W-1:0]        out_year,
    output logic                              not_after_input,
    output logic                              before_input,
    output logic                              date_valid,
    // configuration write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cds_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cds_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_STEP = 3'b010,
        ST_SHOW = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    date_t                cur_reg, cur_next;
    date_t                latest_reg, latest_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    date_t                cmp_reg, cmp_next;
    logic                 back_reg, back_next;
    date_t                res_date_reg, res_date_next;
    flags_t               res_flags_reg, res_flags_next;

    logic                 req_accept;
    logic                 cfg_write;
    date_t                in_date;
    date_t                step_date;
    logic                 step_ok;
    flags_t               flags;
    logic [COUNT_W-1:0]   count_clamped;

    assign in_date   = '{year: in_year, month: in_month, day: in_day};
    assign req_stall = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign count_clamped = (day_count > COUNT_MAX) ? COUNT_MAX : day_count;

    cds_step_unit u_step (
        .back (back_reg),
        .cur  (cur_reg),
        .nxt  (step_date),
        .ok   (step_ok)
    );

    cds_check u_check (
        .cur      (cur_reg),
        .ref_date (cmp_reg),
        .latest   (latest_reg),
        .flags    (flags)
    );

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        cmp_next       = cmp_reg;
        back_next      = back_reg;
        res_date_next  = res_date_reg;
        res_flags_next = res_flags_reg;
        latest_next    = latest_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_LATEST_DAY:   latest_next.day   = cfg_data[DAY_W-1:0];
                CFG_LATEST_MONTH: latest_next.month = cfg_data[MONTH_W-1:0];
                CFG_LATEST_YEAR:  latest_next.year  = cfg_data[YEAR_W-1:0];
                default:          latest_next       = latest_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    cmp_next   = in_date;
                    back_next  = (action == ACT_SUB);
                    cnt_next   = '0;
                    state_next = ST_STEP;
                    case (action)
                        ACT_LOAD: cur_next = in_date;
                        ACT_ADD:  cnt_next = count_clamped;
                        ACT_SUB:  cnt_next = count_clamped;
                        default:  cnt_next = '0;
                    endcase
                end
            end
            ST_STEP:
            begin
                // a step past the year range ends the request early
                if (cnt_reg == '0 || !step_ok)
                begin
                    res_date_next  = cur_reg;
                    res_flags_next = flags;
                    state_next     = ST_SHOW;
                end
                else
                begin
                    cur_next = step_date;
                    cnt_next = cnt_reg - 12'd1;
                end
            end
            ST_SHOW:
            begin
                if (!res_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cur_reg    <= '0;
            cnt_reg    <= '0;
            latest_reg <= '{year: RESET_LATEST_YEAR, month: RESET_LATEST_MONTH,
                            day: RESET_LATEST_DAY};
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            cnt_reg    <= cnt_next;
            latest_reg <= latest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_reg       <= cmp_next;
        back_reg      <= back_next;
        res_date_reg  <= res_date_next;
        res_flags_reg <= res_flags_next;
    end

    assign res_valid       = (state_reg == ST_SHOW);
    assign out_day         = res_date_reg.day;
    assign out_month       = res_date_reg.month;
    assign out_year        = res_date_reg.year;
    assign not_after_input = res_flags_reg.not_after;
    assign before_input    = res_flags_reg.earlier;
    assign date_valid      = res_flags_reg.valid;

    `ASSERT_IMPLIES(a_no_req_with_result, clk, rst_n, res_valid, req_stall, "request taken while result pending")
    `ASSERT_NEXT(a_count_down, clk, rst_n, (state_reg == ST_STEP) && (cnt_reg != '0) && step_ok, cnt_reg == $past(cnt_reg) - 12'd1, "step counter did not count down")
    `ASSERT_NEXT(a_load_stores, clk, rst_n, req_accept && (action == ACT_LOAD), cur_reg == $past(in_date), "load did not store the request date")
    `ASSERT_NEXT(a_result_once, clk, rst_n, res_valid && !res_stall, !res_valid, "result shown twice")

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for calendar_date_stepper_unit: a directed table, then random
// load/step sequences under several latest-date settings, checked against a local date model.
// Depends on cds_pkg and the calendar_date_stepper_unit rtl.
module tb;
    import cds_pkg::*;

    typedef struct packed {
        action_t            act;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [COUNT_W-1:0] count;
    } date_request_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               not_after;
        logic               earlier;
        logic               valid;
    } date_result_t;

    typedef struct {
        date_request_t req;
        bit            known;
        date_result_t  want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    logic [1:0]            action;
    logic [DAY_W-1:0]      in_day;
    logic [MONTH_W-1:0]    in_month;
    logic [YEAR_W-1:0]     in_year;
    logic [COUNT_W-1:0]    day_count;
    logic                  res_valid;
    logic                  res_stall;
    logic [DAY_W-1:0]      out_day;
    logic [MONTH_W-1:0]    out_month;
    logic [YEAR_W-1:0]     out_year;
    logic                  not_after_input;
    logic                  before_input;
    logic                  date_valid;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // local copy of the stored date and the latest allowed date
    int cur_d, cur_m, cur_y;
    int lim_d, lim_m, lim_y;

    date_result_t expected_dates[$];
    stim_row_t    stim_table[$];
    date_result_t head_result;

    int  mismatches = 0;
    int  results_seen = 0;
    int  requests_sent = 0;
    int  settings_used = 1;
    int  hold_cycles = 0;
    bit  no_idle = 1'b0;

    calendar_date_stepper_unit DUT (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #25_000_000;
        $display("calendar_date_stepper_unit regression: fail");
        $finish;
    end

    // ---------------- date model ----------------

    function automatic bit leap_year(int y);
        return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    endfunction

    // months outside 1..12 count as 31 days
    function automatic int month_days(int m, int y);
        if (m == 2)
            return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic int date_key(int d, int m, int y);
        return (y << 9) | (m << 5) | d;
    endfunction

    function automatic bit next_day();
        if (cur_d >= month_days(cur_m, cur_y))
        begin
            if (cur_m + 1 > 12)
            begin
                if (cur_y >= int'(YEAR_MAX))
                    return 1'b0;
                cur_y++;
                cur_m = 1;
            end
            else
                cur_m++;
            cur_d = 1;
        end
        else
            cur_d++;
        return 1'b1;
    endfunction

    function automatic bit prev_day();
        if (cur_d <= 1)
        begin
            if (cur_m <= 1)
            begin
                if (cur_y == 0)
                    return 1'b0;
                cur_y--;
                cur_m = 12;
            end
            else
                cur_m--;
            cur_d = month_days(cur_m, cur_y);
        end
        else
            cur_d--;
        return 1'b1;
    endfunction

    function automatic date_result_t predict_date(date_request_t r);
        date_result_t res;
        int           n;
        int           i;
        int           key_in;
        bit           going;
        n = int'(r.count);
        if (n > int'(COUNT_MAX))
            n = int'(COUNT_MAX);
        going = 1'b1;
        case (r.act)
            ACT_LOAD:
            begin
                cur_d = int'(r.day);
                cur_m = int'(r.month);
                cur_y = int'(r.year);
            end
            ACT_ADD:
                for (i = 0; i < n && going; i++)
                    going = next_day();
            ACT_SUB:
                for (i = 0; i < n && going; i++)
                    going = prev_day();
            default: ;
        endcase
        key_in        = date_key(int'(r.day), int'(r.month), int'(r.year));
        res.day       = DAY_W'(cur_d);
        res.month     = MONTH_W'(cur_m);
        res.year      = YEAR_W'(cur_y);
        res.not_after = date_key(cur_d, cur_m, cur_y) <= key_in;
        res.earlier   = date_key(cur_d, cur_m, cur_y) < key_in;
        res.valid     = cur_y >= int'(YEAR_MIN) && cur_m >= 1 && cur_m <= 12
                        && cur_d >= 1 && cur_d <= month_days(cur_m, cur_y)
                        && date_key(cur_d, cur_m, cur_y) <= date_key(lim_d, lim_m, lim_y);
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic date_request_t make_request(action_t a, int d, int m, int y, int n);
        date_request_t r;
        r.act   = a;
        r.day   = DAY_W'(d);
        r.month = MONTH_W'(m);
        r.year  = YEAR_W'(y);
        r.count = COUNT_W'(n);
        return r;
    endfunction

    function automatic date_result_t result_of(int d, int m, int y, bit na, bit bf, bit vl);
        date_result_t r;
        r.day       = DAY_W'(d);
        r.month     = MONTH_W'(m);
        r.year      = YEAR_W'(y);
        r.not_after = na;
        r.earlier   = bf;
        r.valid     = vl;
        return r;
    endfunction

    function automatic void add_row(action_t a, int d, int m, int y, int n);
        stim_row_t row;
        row.req   = make_request(a, d, m, y, n);
        row.known = 1'b0;
        row.want  = '0;
        stim_table.push_back(row);
    endfunction

    function automatic void add_known(action_t a, int d, int m, int y, int n, date_result_t w);
        stim_row_t row;
        row.req   = make_request(a, d, m, y, n);
        row.known = 1'b1;
        row.want  = w;
        stim_table.push_back(row);
    endfunction

    function automatic int pick_count();
        int b;
        b = $urandom_range(0, 99);
        if (b < 65)
            return $urandom_range(0, 40);
        if (b < 90)
            return $urandom_range(41, 800);
        if (b < 98)
            return $urandom_range(801, 4094);
        return int'(COUNT_MAX);
    endfunction

    task automatic issue_request(input date_request_t r, input bit known,
                                 input date_result_t want);
        date_result_t model_out;
        int           gap;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
            end
        end
        @(negedge clk);
        req_valid <= 1'b1;
        action    <= r.act;
        in_day    <= r.day;
        in_month  <= r.month;
        in_year   <= r.year;
        day_count <= r.count;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        model_out = predict_date(r);
        expected_dates.push_back(known ? want : model_out);
        requests_sent++;
    endtask

    // drop valid and let every open request drain before touching the registers
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_latest(input cfg_idx_t idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_LATEST_DAY:   lim_d = value & 'h1F;
            CFG_LATEST_MONTH: lim_m = value & 'hF;
            CFG_LATEST_YEAR:  lim_y = value & 'hFFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_latest(input int d, input int m, input int y);
        write_latest(CFG_LATEST_DAY, d);
        write_latest(CFG_LATEST_MONTH, m);
        write_latest(CFG_LATEST_YEAR, y);
        settings_used++;
    endtask

    // mostly a valid load followed by a few steps; the rest is raw noise
    task automatic run_random_phase(input int quota);
        int      issued;
        int      steps;
        int      d, m, y, k;
        action_t a;
        issued = 0;
        while (issued < quota)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                k = $urandom_range(0, 9);
                if (k == 0)
                    y = $urandom_range(4093, 4095);
                else if (k == 1)
                    y = $urandom_range(0, 2);
                else
                    y = $urandom_range(1890, 2110);
                m = $urandom_range(1, 12);
                d = $urandom_range(1, month_days(m, y));
                issue_request(make_request(ACT_LOAD, d, m, y, $urandom_range(0, 4095)),
                              1'b0, '0);
                steps = $urandom_range(1, 5);
                issued += steps + 1;
                repeat (steps)
                begin
                    a = $urandom_range(0, 1) ? ACT_ADD : ACT_SUB;
                    k = $urandom_range(0, 2);
                    if (k == 0)
                        // compare against the date as it stands: equal or one day off
                        issue_request(make_request(a, cur_d, cur_m, cur_y,
                                                   $urandom_range(0, 1)), 1'b0, '0);
                    else if (k == 1)
                    begin
                        k = $urandom_range(0, 2);
                        y = cur_y + k - 1;
                        if (y < 0)
                            y = 0;
                        if (y > 4095)
                            y = 4095;
                        issue_request(make_request(a, $urandom_range(1, 28),
                                                   $urandom_range(1, 12), y, pick_count()),
                                      1'b0, '0);
                    end
                    else
                        issue_request(make_request(a, $urandom_range(0, 31),
                                                   $urandom_range(0, 12),
                                                   $urandom_range(0, 4095), pick_count()),
                                      1'b0, '0);
                end
            end
            else
            begin
                issue_request(make_request(action_t'($urandom_range(0, 3)),
                                           $urandom_range(0, 31), $urandom_range(0, 15),
                                           $urandom_range(0, 4095), pick_count()),
                              1'b0, '0);
                issued++;
            end
        end
    endtask

    // ---------------- result side ----------------

    initial
    begin
        int  burst;
        bit  stalling;
        res_stall = 1'b0;
        burst = 0;
        stalling = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_stall <= 1'b1;
                hold_cycles--;
            end
            else if (burst > 0)
            begin
                res_stall <= stalling && !no_idle;
                burst--;
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    // clear stretch
                    stalling = 1'b0;
                    burst = $urandom_range(20, 60);
                end
                else
                begin
                    stalling = !no_idle && $urandom_range(0, 2) == 0;
                    burst = $urandom_range(1, 8) - 1;
                end
                res_stall <= stalling;
            end
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_dates.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                         $time, out_day, out_month, out_year);
            end
            else
            begin
                head_result = expected_dates.pop_front();
                check_field("out_day", int'(head_result.day), int'(out_day));
                check_field("out_month", int'(head_result.month), int'(out_month));
                check_field("out_year", int'(head_result.year), int'(out_year));
                check_field("not_after_input", int'(head_result.not_after),
                            int'(not_after_input));
                check_field("before_input", int'(head_result.earlier), int'(before_input));
                check_field("date_valid", int'(head_result.valid), int'(date_valid));
                results_seen++;
            end
        end
    end

    // ---------------- main sequence ----------------

    initial
    begin
        int i;
        int directed;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        action    = ACT_LOAD;
        in_day    = '0;
        in_month  = '0;
        in_year   = '0;
        day_count = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LATEST_DAY;
        cfg_data  = '0;
        cur_d = 0;
        cur_m = 0;
        cur_y = 0;
        lim_d = int'(RESET_LATEST_DAY);
        lim_m = int'(RESET_LATEST_MONTH);
        lim_y = int'(RESET_LATEST_YEAR);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // unused register index must leave the reset limit alone
        write_latest(CFG_UNUSED, 'hFFF);

        // reset state, year floor and ceiling, limit edges
        add_known(ACT_NONE, 0, 0, 0, 0, result_of(0, 0, 0, 1, 0, 0));
        add_known(ACT_SUB, 0, 0, 0, 5, result_of(0, 0, 0, 1, 0, 0));
        add_known(ACT_LOAD, 31, 12, 4095, 4095, result_of(31, 12, 4095, 1, 0, 0));
        add_known(ACT_ADD, 1, 1, 0, 4095, result_of(31, 12, 4095, 0, 0, 0));
        add_known(ACT_LOAD, 1, 1, 2000, 0, result_of(1, 1, 2000, 1, 0, 1));
        add_known(ACT_LOAD, 2, 1, 2000, 0, result_of(2, 1, 2000, 1, 0, 0));
        add_known(ACT_LOAD, 31, 12, 1899, 0, result_of(31, 12, 1899, 1, 0, 0));
        add_row(ACT_ADD, 1, 1, 1900, 1);
        // leap rules: 2000 leap, 1900 and 2100 not
        add_row(ACT_LOAD, 28, 2, 2000, 0);
        add_row(ACT_ADD, 29, 2, 2000, 1);
        add_row(ACT_ADD, 1, 3, 2000, 1);
        add_row(ACT_LOAD, 28, 2, 1900, 0);
        add_row(ACT_ADD, 29, 2, 1900, 1);
        add_row(ACT_LOAD, 1, 3, 2100, 0);
        add_row(ACT_SUB, 28, 2, 2100, 1);
        // out-of-range month and day stored as loaded, then stepped
        add_row(ACT_LOAD, 0, 15, 2001, 0);
        add_row(ACT_SUB, 31, 14, 2001, 1);
        add_row(ACT_ADD, 1, 1, 2002, 2);
        add_row(ACT_LOAD, 31, 0, 2001, 0);
        add_row(ACT_ADD, 1, 1, 2001, 1);
        add_row(ACT_LOAD, 31, 4, 2001, 0);
        add_row(ACT_ADD, 0, 5, 2001, 1);
        add_row(ACT_LOAD, 1, 1, 1, 0);
        add_row(ACT_SUB, 30, 12, 0, 2);
        add_row(ACT_NONE, 31, 15, 4095, 4095);

        for (i = 0; i < stim_table.size(); i++)
            issue_request(stim_table[i].req, stim_table[i].known, stim_table[i].want);
        directed = requests_sent;
        settle();

        set_latest(31, 12, 4095);
        run_random_phase(28);
        settle();

        // long receiver hold-off so the request side backs up
        set_latest(1, 1, 0);
        hold_cycles = 400;
        run_random_phase(28);
        settle();

        set_latest($urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(1900, 2100));
        run_random_phase(28);
        settle();

        no_idle = 1'b1;
        set_latest(29, 2, 2024);
        run_random_phase(28);
        settle();
        repeat (8) @(posedge clk);

        $display("covered %0d requests (%0d directed) across %0d latest-date settings",
                 requests_sent, directed, settings_used);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("calendar_date_stepper_unit regression: pass");
        else
            $display("calendar_date_stepper_unit regression: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/cds_pkg.sv
design/cds_step_unit.sv
design/cds_check.sv
design/calendar_date_stepper_unit.sv
bench/tb.sv
